// ===== hdl/bps_pkg.sv =====
// Package for the buzzer pattern sequencer: command, pattern and step codes,
// register indexes and the sequencer state type. No dependencies.
`default_nettype none

package bps_pkg;

  localparam int CMD_W  = 2;
  localparam int PAT_W  = 3;
  localparam int STEP_W = 3;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_OFF  = 2'd2;

  localparam logic [PAT_W-1:0] PAT_OFF    = 3'd0;
  localparam logic [PAT_W-1:0] PAT_SHORT  = 3'd1;
  localparam logic [PAT_W-1:0] PAT_DOUBLE = 3'd2;
  localparam logic [PAT_W-1:0] PAT_LONG   = 3'd3;
  localparam logic [PAT_W-1:0] PAT_ERROR  = 3'd4;

  localparam logic [STEP_W-1:0] STEP_START = 3'd0;
  localparam logic [STEP_W-1:0] STEP_BEEP1 = 3'd1;
  localparam logic [STEP_W-1:0] STEP_GAP   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_BEEP2 = 3'd3;
  localparam logic [STEP_W-1:0] STEP_TAIL  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_BEEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_BEEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_TAIL = 2'd3;

  localparam logic [CFG_W-1:0] SHORT_BEEP_RST = 16'd100;
  localparam logic [CFG_W-1:0] LONG_BEEP_RST  = 16'd800;
  localparam logic [CFG_W-1:0] GAP_RST        = 16'd150;
  localparam logic [CFG_W-1:0] ERROR_TAIL_RST = 16'd500;

  typedef struct packed {
    logic [PAT_W-1:0]  pattern_sel;
    logic [STEP_W-1:0] step_index;
    logic              running;
    logic              sound;
  } seq_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/buzzer_pattern_sequencer_unit.sv =====
// Buzzer pattern sequencer top level: input register, state update, result register.
// Depends on bps_pkg.
// An accepted input beat passes the input register, then the result register.
// Throughput: one beat per cycle unless out_stall holds the result register; set
// by the combinational state update between the input and result registers.
// Reset (rst_n, synchronous): sequencer idle, buzzer off, timing registers at defaults.
`default_nettype none

module buzzer_pattern_sequencer_unit #(
  parameter int TIME_BITS = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire [bps_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire [bps_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire [bps_pkg::CMD_W-1:0]        in_cmd,
  input  wire [bps_pkg::PAT_W-1:0]        in_pattern,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic                            out_buzzer_on,
  output logic                            out_busy_res
);
  import bps_pkg::*;

  localparam int CW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  logic [CFG_W-1:0] short_beep_r, long_beep_r, gap_r, error_tail_r;

  logic             s1_valid_r;
  logic [CMD_W-1:0] s1_cmd_r;
  logic [PAT_W-1:0] s1_pat_r;
  logic             s1_adv;

  seq_ctl_t             ctl_r, ctl_nxt;
  logic [TIME_BITS-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic [CFG_W-1:0]     need;
  logic                 reached, pat_known;

  logic out_valid_r, out_buzzer_on_r, out_busy_res_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_beep_r <= SHORT_BEEP_RST;
      long_beep_r  <= LONG_BEEP_RST;
      gap_r        <= GAP_RST;
      error_tail_r <= ERROR_TAIL_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SHORT_BEEP: short_beep_r <= cfg_wdata;
        REG_LONG_BEEP:  long_beep_r  <= cfg_wdata;
        REG_GAP:        gap_r        <= cfg_wdata;
        REG_ERROR_TAIL: error_tail_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd_r <= in_cmd;
      s1_pat_r <= in_pattern;
    end
  end

  // step duration and compare
  assign elapsed_inc = (elapsed_r == TIME_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign pat_known   = (ctl_r.pattern_sel == PAT_SHORT) || (ctl_r.pattern_sel == PAT_DOUBLE) ||
                       (ctl_r.pattern_sel == PAT_LONG)  || (ctl_r.pattern_sel == PAT_ERROR);

  always_comb begin
    need = short_beep_r;
    if (ctl_r.pattern_sel == PAT_LONG) begin
      need = long_beep_r;
    end else if (ctl_r.pattern_sel != PAT_SHORT) begin
      case (ctl_r.step_index)
        STEP_GAP:  need = gap_r;
        STEP_TAIL: need = error_tail_r;
        default:   need = short_beep_r;
      endcase
    end
  end

  assign reached = CW'(elapsed_inc) >= CW'(need);

  // state update
  always_comb begin
    ctl_nxt     = ctl_r;
    elapsed_nxt = elapsed_r;
    case (s1_cmd_r)
      CMD_TICK: begin
        if (ctl_r.running) begin
          if (!pat_known) begin
            ctl_nxt.pattern_sel = PAT_OFF;
            ctl_nxt.running     = 1'b0;
            ctl_nxt.sound       = 1'b0;
          end else if (ctl_r.step_index == STEP_START) begin
            ctl_nxt.sound      = 1'b1;
            ctl_nxt.step_index = STEP_BEEP1;
            elapsed_nxt        = '0;
          end else begin
            elapsed_nxt = elapsed_inc;
            if (ctl_r.pattern_sel == PAT_SHORT || ctl_r.pattern_sel == PAT_LONG) begin
              if (reached) begin
                ctl_nxt.sound   = 1'b0;
                ctl_nxt.running = 1'b0;
              end
            end else begin
              case (ctl_r.step_index)
                STEP_BEEP1: begin
                  if (reached) begin
                    ctl_nxt.sound      = 1'b0;
                    ctl_nxt.step_index = STEP_GAP;
                    elapsed_nxt        = '0;
                  end
                end
                STEP_GAP: begin
                  if (reached) begin
                    ctl_nxt.sound      = 1'b1;
                    ctl_nxt.step_index = STEP_BEEP2;
                    elapsed_nxt        = '0;
                  end
                end
                STEP_BEEP2: begin
                  if (reached) begin
                    ctl_nxt.sound = 1'b0;
                    if (ctl_r.pattern_sel == PAT_DOUBLE) begin
                      ctl_nxt.running = 1'b0;
                    end else begin
                      ctl_nxt.step_index = STEP_TAIL;
                      elapsed_nxt        = '0;
                    end
                  end
                end
                STEP_TAIL: begin
                  if (ctl_r.pattern_sel == PAT_ERROR && reached) begin
                    ctl_nxt.running = 1'b0;
                  end
                end
                default: ;
              endcase
            end
          end
        end
      end
      CMD_SET: begin
        ctl_nxt.pattern_sel = s1_pat_r;
        if (s1_pat_r == PAT_OFF) begin
          ctl_nxt.sound   = 1'b0;
          ctl_nxt.running = 1'b0;
        end else begin
          ctl_nxt.step_index = STEP_START;
          ctl_nxt.running    = 1'b1;
          elapsed_nxt        = '0;
        end
      end
      CMD_OFF: begin
        ctl_nxt.pattern_sel = PAT_OFF;
        ctl_nxt.running     = 1'b0;
        ctl_nxt.sound       = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r     <= '0;
      elapsed_r <= '0;
    end else if (s1_adv) begin
      ctl_r     <= ctl_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_buzzer_on_r <= ctl_nxt.sound;
      out_busy_res_r  <= ctl_nxt.running;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_buzzer_on = out_buzzer_on_r;
  assign out_busy_res  = out_busy_res_r;

  // checks
  a_sound_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.sound |-> ctl_r.running)
    else $error("buzzer sounding while sequencer idle");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.step_index <= STEP_TAIL)
    else $error("step index out of range");

  a_off_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_cmd_r == CMD_OFF) |=> (!ctl_r.running && ctl_r.pattern_sel == PAT_OFF))
    else $error("off command did not idle the sequencer");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && in_stall) |=> (s1_valid_r && $stable(s1_cmd_r) && $stable(s1_pat_r)))
    else $error("input register lost a stalled beat");

  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_buzzer_on_r == ctl_r.sound && out_busy_res_r == ctl_r.running))
    else $error("result does not reflect updated state");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for buzzer_pattern_sequencer_unit: directed and random tick/set/off beats
// checked against a cycle-free model of the beep sequencer. Needs bps_pkg and the unit.
`timescale 1ns / 100ps

module tb_top;
  import bps_pkg::*;

  localparam int TIME_BITS = 16;
  localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ERR_PRINT_MAX = 20;

  typedef struct packed {
    logic buzzer_on;
    logic busy;
  } pin_state_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [CMD_W-1:0] in_cmd;
  logic [PAT_W-1:0] in_pattern;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_buzzer_on;
  logic out_busy_res;

  // sequencer copy
  logic [PAT_W-1:0] sq_pat;
  logic [STEP_W-1:0] sq_step;
  logic [TIME_BITS-1:0] sq_elapsed;
  logic sq_running;
  logic sq_sound;
  logic [CFG_W-1:0] dur_short, dur_long, dur_gap, dur_tail;

  pin_state_t pin_exp_q[$];
  int err_cnt = 0;
  int quiet_cycles = 0;
  int stall_hold = 0;
  bit idle_on = 1'b1;

  buzzer_pattern_sequencer_unit #(
    .TIME_BITS(TIME_BITS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_pattern(in_pattern),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_buzzer_on(out_buzzer_on),
    .out_busy_res(out_busy_res)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // One tick of the sequencer.
  function automatic void run_tick();
    if (!sq_running) return;
    if (sq_pat != PAT_SHORT && sq_pat != PAT_DOUBLE && sq_pat != PAT_LONG &&
        sq_pat != PAT_ERROR) begin
      sq_pat = PAT_OFF;
      sq_running = 1'b0;
      sq_sound = 1'b0;
      return;
    end
    if (sq_step == STEP_START) begin
      sq_sound = 1'b1;
      sq_elapsed = '0;
      sq_step = STEP_BEEP1;
      return;
    end
    if (sq_elapsed != '1) sq_elapsed = sq_elapsed + 1'b1;
    if (sq_pat == PAT_SHORT || sq_pat == PAT_LONG) begin
      if (sq_elapsed >= ((sq_pat == PAT_SHORT) ? dur_short : dur_long)) begin
        sq_sound = 1'b0;
        sq_running = 1'b0;
      end
      return;
    end
    case (sq_step)
      STEP_BEEP1: begin
        if (sq_elapsed >= dur_short) begin
          sq_sound = 1'b0;
          sq_elapsed = '0;
          sq_step = STEP_GAP;
        end
      end
      STEP_GAP: begin
        if (sq_elapsed >= dur_gap) begin
          sq_sound = 1'b1;
          sq_elapsed = '0;
          sq_step = STEP_BEEP2;
        end
      end
      STEP_BEEP2: begin
        if (sq_elapsed >= dur_short) begin
          if (sq_pat == PAT_DOUBLE) begin
            sq_sound = 1'b0;
            sq_running = 1'b0;
          end else begin
            sq_sound = 1'b0;
            sq_elapsed = '0;
            sq_step = STEP_TAIL;
          end
        end
      end
      STEP_TAIL: begin
        if (sq_pat == PAT_ERROR && sq_elapsed >= dur_tail) sq_running = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic pin_state_t predict_pin_state(logic [CMD_W-1:0] c, logic [PAT_W-1:0] p);
    pin_state_t res;
    case (c)
      CMD_TICK: run_tick();
      CMD_SET: begin
        sq_pat = p;
        if (p == PAT_OFF) begin
          sq_sound = 1'b0;
          sq_running = 1'b0;
        end else begin
          sq_step = STEP_START;
          sq_elapsed = '0;
          sq_running = 1'b1;
        end
      end
      CMD_OFF: begin
        sq_pat = PAT_OFF;
        sq_running = 1'b0;
        sq_sound = 1'b0;
      end
      default: ;
    endcase
    res.buzzer_on = sq_sound;
    res.busy = sq_running;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= ERR_PRINT_MAX) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic send_beat(logic [CMD_W-1:0] c, logic [PAT_W-1:0] p);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_pattern <= p;
    do @(posedge clk); while (in_stall !== 1'b0);
    pin_exp_q.push_back(predict_pin_state(c, p));
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pin_exp_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SHORT_BEEP: dur_short = val;
      REG_LONG_BEEP:  dur_long = val;
      REG_GAP:        dur_gap = val;
      REG_ERROR_TAIL: dur_tail = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timing(int s, int l, int g, int t);
    wait_results_done();
    write_reg(REG_SHORT_BEEP, s[CFG_W-1:0]);
    write_reg(REG_LONG_BEEP, l[CFG_W-1:0]);
    write_reg(REG_GAP, g[CFG_W-1:0]);
    write_reg(REG_ERROR_TAIL, t[CFG_W-1:0]);
  endtask

  task automatic play_pattern(logic [PAT_W-1:0] p);
    send_beat(CMD_SET, p);
    while (sq_running) send_beat(CMD_TICK, PAT_W'($urandom_range(0, 7)));
  endtask

  // long and error together cover every reset duration
  task automatic test_default_timing();
    play_pattern(PAT_LONG);
    play_pattern(PAT_ERROR);
  endtask

  task automatic test_directed();
    set_timing(2, 3, 1, 2);
    send_beat(CMD_TICK, PAT_ERROR);
    send_beat(CMD_RSVD, 3'd7);
    send_beat(CMD_SET, PAT_SHORT);
    repeat (3) send_beat(CMD_TICK, PAT_OFF);
    send_beat(CMD_SET, PAT_LONG);
    send_beat(CMD_TICK, PAT_OFF);
    // new pattern while the pin is high
    send_beat(CMD_SET, PAT_ERROR);
    repeat (8) send_beat(CMD_TICK, PAT_OFF);
    send_beat(CMD_SET, PAT_DOUBLE);
    send_beat(CMD_TICK, PAT_OFF);
    send_beat(CMD_SET, PAT_OFF);
    send_beat(CMD_SET, 3'd5);
    send_beat(CMD_TICK, PAT_OFF);
    send_beat(CMD_SET, 3'd7);
    send_beat(CMD_TICK, PAT_OFF);
    send_beat(CMD_SET, 3'd6);
    send_beat(CMD_OFF, 3'd6);
  endtask

  task automatic test_random_patterns(int n, int lo, int hi);
    logic [CMD_W-1:0] c;
    logic [PAT_W-1:0] p;
    int r;
    set_timing($urandom_range(lo, hi), $urandom_range(lo, hi), $urandom_range(lo, hi),
               $urandom_range(lo, hi));
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (i == n / 2) wait_results_done();
      r = $urandom_range(0, 99);
      p = PAT_W'($urandom_range(0, 7));
      if (sq_running) begin
        if (r < 86) c = CMD_TICK;
        else if (r < 92) c = CMD_SET;
        else if (r < 97) c = CMD_OFF;
        else c = CMD_RSVD;
      end else begin
        if (r < 55) begin
          c = CMD_SET;
          p = PAT_W'($urandom_range(PAT_SHORT, PAT_ERROR));
        end else if (r < 70) c = CMD_SET;
        else if (r < 85) c = CMD_TICK;
        else if (r < 93) c = CMD_OFF;
        else c = CMD_RSVD;
      end
      send_beat(c, p);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_max_durations();
    set_timing(65535, 65535, 65535, 65535);
    idle_on = 1'b0;
    send_beat(CMD_SET, PAT_LONG);
    repeat (5) send_beat(CMD_TICK, PAT_OFF);
    idle_on = 1'b1;
    send_beat(CMD_SET, PAT_DOUBLE);
    repeat (5) send_beat(CMD_TICK, PAT_OFF);
    send_beat(CMD_SET, PAT_ERROR);
    repeat (5) send_beat(CMD_TICK, PAT_OFF);
    send_beat(CMD_OFF, PAT_OFF);
  endtask

  // result checker
  always @(posedge clk) begin
    pin_state_t exp_st;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pin_exp_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        exp_st = pin_exp_q.pop_front();
        if (out_buzzer_on !== exp_st.buzzer_on)
          report_mismatch($sformatf("buzzer_on got %b exp %b", out_buzzer_on,
                                    exp_st.buzzer_on));
        if (out_busy_res !== exp_st.busy)
          report_mismatch($sformatf("busy_res got %b exp %b", out_busy_res, exp_st.busy));
      end
    end
  end

  always @(negedge clk) begin
    if (!idle_on) begin
      out_stall <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[buzzer_pattern_sequencer_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_SHORT_BEEP;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_cmd = CMD_TICK;
    in_pattern = PAT_OFF;
    sq_pat = PAT_OFF;
    sq_step = STEP_START;
    sq_elapsed = '0;
    sq_running = 1'b0;
    sq_sound = 1'b0;
    dur_short = SHORT_BEEP_RST;
    dur_long = LONG_BEEP_RST;
    dur_gap = GAP_RST;
    dur_tail = ERROR_TAIL_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_timing();
    test_directed();
    test_random_patterns(100, 1, 3);
    test_random_patterns(100, 0, 2);
    test_random_patterns(100, 1, 12);
    test_random_patterns(100, 0, 6);
    test_max_durations();

    wait_results_done();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[buzzer_pattern_sequencer_unit] OK");
    end else begin
      $display("[buzzer_pattern_sequencer_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bps_pkg.sv
hdl/buzzer_pattern_sequencer_unit.sv
test/tb_top.sv
